// ----- design/sync_xor_frame_receiver_assert.svh -----
// assertion macros for the frame receiver top module
`ifndef SYNC_XOR_FRAME_RECEIVER_ASSERT_SVH
`define SYNC_XOR_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SXFR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SXFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/sxfr_pkg.sv -----
// types and constants shared by the frame receiver modules
`default_nettype none

package sxfr_pkg;

    localparam int PAYLOAD_LEN = 8;
    localparam int IDX_W       = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
    localparam int CNT_W       = $clog2(PAYLOAD_LEN + 1);
    localparam int ADDR_W      = IDX_W + 1;
    localparam int RAM_DEPTH   = 2 ** ADDR_W;

    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'hCC;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_SYNC2 = 2'd1,
        PH_BODY  = 2'd2
    } phase_t;

    // frame handed from the parser to the emitter
    typedef struct packed {
        logic valid;
        logic bank;
    } commit_t;

    // status of the frame queue
    typedef struct packed {
        logic       empty;
        logic       full;
        logic       head;
        logic [1:0] busy;
    } qstat_t;

endpackage

`default_nettype wire

// ----- design/sxfr_ram.sv -----
// generic simple dual-port ram with registered read
`default_nettype none

module sxfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/sxfr_front.sv -----
// byte parser: sync hunt, payload capture into ram, checksum check
`default_nettype none

module sxfr_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [7:0]            rx_byte,
    input  wire logic                  line_error,
    input  wire logic                  output_busy,
    input  wire logic [1:0]            busy_mask,
    output logic                       wr_en,
    output logic [sxfr_pkg::ADDR_W-1:0] wr_addr,
    output logic [7:0]                 wr_data,
    output sxfr_pkg::commit_t          commit
);
    import sxfr_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       xor_reg, xor_next;
    logic             wbank_reg, wbank_next;
    logic             take;
    logic             body_done;

    assign body_done = (cnt_reg == CNT_W'(PAYLOAD_LEN));
    // stall only when a payload beat would land in a bank still being emitted
    assign full = (phase_reg == PH_BODY) && !body_done && busy_mask[wbank_reg];
    assign take = push && !full && !line_error;

    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            case (phase_reg)
                PH_SYNC2:
                begin
                    phase_next = (rx_byte == SYNC_SECOND) ? PH_BODY : PH_HUNT;
                end
                PH_BODY:
                begin
                    if (body_done)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                default:
                begin
                    phase_next = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
                end
            endcase
        end
    end

    always_comb
    begin
        cnt_next     = cnt_reg;
        xor_next     = xor_reg;
        wbank_next   = wbank_reg;
        wr_en        = 1'b0;
        wr_addr      = {wbank_reg, cnt_reg[IDX_W-1:0]};
        wr_data      = rx_byte;
        commit.valid = 1'b0;
        commit.bank  = wbank_reg;
        if (take)
        begin
            case (phase_reg)
                PH_SYNC2:
                begin
                    if (rx_byte == SYNC_SECOND)
                    begin
                        cnt_next = '0;
                        xor_next = xor_reg ^ SYNC_SECOND;
                    end
                end
                PH_BODY:
                begin
                    if (!body_done)
                    begin
                        wr_en    = 1'b1;
                        xor_next = xor_reg ^ rx_byte;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else if ((rx_byte == xor_reg) && !output_busy)
                    begin
                        commit.valid = 1'b1;
                        wbank_next   = ~wbank_reg;
                    end
                end
                default:
                begin
                    if (rx_byte == SYNC_FIRST)
                    begin
                        xor_next = SYNC_FIRST;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            cnt_reg   <= '0;
            xor_reg   <= '0;
            wbank_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            xor_reg   <= xor_next;
            wbank_reg <= wbank_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/sxfr_queue.sv -----
// two-entry queue of verified frame banks between parser and emitter
`default_nettype none

module sxfr_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sxfr_pkg::commit_t commit,
    input  wire logic              q_pop,
    output sxfr_pkg::qstat_t       qstat
);
    import sxfr_pkg::*;

    logic       slot_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        count_next = count_reg;
        if (commit.valid)
        begin
            wp_next = ~wp_reg;
        end
        if (q_pop)
        begin
            rp_next = ~rp_reg;
        end
        case ({commit.valid, q_pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_comb
    begin
        qstat.empty = (count_reg == 2'd0);
        qstat.full  = (count_reg == 2'd2);
        qstat.head  = slot_reg[rp_reg];
        qstat.busy  = 2'b00;
        if (count_reg != 2'd0)
        begin
            qstat.busy[slot_reg[rp_reg]] = 1'b1;
        end
        if (count_reg == 2'd2)
        begin
            qstat.busy[slot_reg[~rp_reg]] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit.valid)
        begin
            slot_reg[wp_reg] <= commit.bank;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/sxfr_back.sv -----
// emitter: reads a queued bank out of ram, one beat per cycle while pop is held
`default_nettype none

module sxfr_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire sxfr_pkg::qstat_t       qstat,
    output logic                        q_pop,
    output logic                        rd_en,
    output logic [sxfr_pkg::ADDR_W-1:0] rd_addr,
    input  wire logic                   pop,
    output logic                        empty,
    output logic [5:0]                  byte_index,
    output logic                        last_byte
);
    import sxfr_pkg::*;

    logic [IDX_W-1:0] k_reg, k_next;
    logic             out_valid_reg, out_valid_next;
    logic [5:0]       idx_reg;
    logic             last_reg;
    logic             k_last;

    // the ram read register doubles as the payload output register
    assign k_last  = (k_reg == IDX_W'(PAYLOAD_LEN - 1));
    assign rd_en   = !qstat.empty && (!out_valid_reg || pop);
    assign rd_addr = {qstat.head, k_reg};
    assign q_pop   = rd_en && k_last;
    assign empty   = !out_valid_reg;

    always_comb
    begin
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        if (rd_en)
        begin
            k_next         = k_last ? '0 : k_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            idx_reg  <= 6'(k_reg);
            last_reg <= k_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign byte_index = idx_reg;
    assign last_byte  = last_reg;

endmodule

`default_nettype wire

// ----- design/sync_xor_frame_receiver.sv -----
// Frame receiver for byte streams of the form 0xAA, 0xCC, PAYLOAD_LEN payload
// bytes and an XOR checksum over all bytes before it. A byte is taken on every
// cycle with push high and full low; bytes flagged with line_error are dropped
// with no effect. A frame that checks and arrives with output_busy low is
// delivered as PAYLOAD_LEN beats (payload_byte, byte_index, last_byte), one
// beat per cycle while pop is held, via the frame queue and the ram read
// register. The payload sits in a two-bank ram: the parser fills one bank
// while the emitter drains the other, so full rises only when a payload byte
// would land in a bank whose frame has not yet been fully read out, i.e. when
// two verified frames are still waiting behind a stalled consumer.
`default_nettype none

module sync_xor_frame_receiver (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] rx_byte,
    input  wire logic       line_error,
    input  wire logic       output_busy,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      payload_byte,
    output logic [5:0]      byte_index,
    output logic            last_byte
);
    import sxfr_pkg::*;

    commit_t             commit;
    qstat_t              qstat;
    logic                q_pop;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [7:0]          wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;

    sxfr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .rx_byte     (rx_byte),
        .line_error  (line_error),
        .output_busy (output_busy),
        .busy_mask   (qstat.busy),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .commit      (commit)
    );

    sxfr_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (commit),
        .q_pop  (q_pop),
        .qstat  (qstat)
    );

    sxfr_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (payload_byte)
    );

    sxfr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .qstat      (qstat),
        .q_pop      (q_pop),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .pop        (pop),
        .empty      (empty),
        .byte_index (byte_index),
        .last_byte  (last_byte)
    );

`include "sync_xor_frame_receiver_assert.svh"

    `SXFR_ASSERT_IMP(a_commit_room, commit.valid, !qstat.full, "frame committed to full queue")
    `SXFR_ASSERT_IMP(a_write_free_bank, wr_en, !qstat.busy[wr_addr[ADDR_W-1]], "payload write into busy bank")
    `SXFR_ASSERT_IMP(a_read_queued, rd_en, !qstat.empty, "ram read with no frame queued")
    `SXFR_ASSERT_NEXT(a_commit_busy, commit.valid, qstat.busy != 2'b00, "committed bank not marked busy")

endmodule

`default_nettype wire

// ----- tb/sv/sync_xor_frame_receiver_tb.sv -----
// self-checking testbench for the sync/xor frame receiver
`default_nettype none

module sync_xor_frame_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sxfr_pkg::*;

    localparam int RAND_BYTES     = 350;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 16;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int STEADY_FROM    = 500;
    localparam int STEADY_TO      = 700;

    typedef struct packed {
        logic [7:0] data;
        logic       err;
        logic       busy;
    } rx_beat_t;

    typedef struct packed {
        logic [7:0] data;
        logic [5:0] idx;
        logic       last;
    } payload_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic [7:0] rx_byte = 8'h00;
    logic       line_error = 1'b0;
    logic       output_busy = 1'b0;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic       last_byte;

    sync_xor_frame_receiver uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .rx_byte     (rx_byte),
        .line_error  (line_error),
        .output_busy (output_busy),
        .empty       (empty),
        .pop         (pop),
        .payload_byte(payload_byte),
        .byte_index  (byte_index),
        .last_byte   (last_byte)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    rx_beat_t      byte_feed[$];
    payload_beat_t payload_due[$];
    int            mismatches = 0;
    int            cyc = 0;
    int            stall_cycles = 0;

    // receiver model state
    phase_t     link_phase = PH_HUNT;
    logic [6:0] body_left = '0;
    logic [7:0] frame_xor = '0;
    logic [7:0] body_store [PAYLOAD_LEN];

    task automatic parse_byte(input logic [7:0] b, input logic err, input logic busy);
        int k;
        if (err)
            return;
        case (link_phase)
            PH_SYNC2:
            begin
                if (b == SYNC_SECOND)
                begin
                    body_left  = 7'(PAYLOAD_LEN);
                    frame_xor  = frame_xor ^ SYNC_SECOND;
                    link_phase = PH_BODY;
                end
                else
                    link_phase = PH_HUNT;
            end
            PH_BODY:
            begin
                if (body_left > 0)
                begin
                    body_store[PAYLOAD_LEN - body_left] = b;
                    frame_xor = frame_xor ^ b;
                    body_left = body_left - 7'd1;
                end
                else
                begin
                    if (b == frame_xor && !busy)
                        for (k = 0; k < PAYLOAD_LEN; k++)
                            payload_due.push_back({body_store[k], 6'(k),
                                                   k == PAYLOAD_LEN - 1});
                    link_phase = PH_HUNT;
                end
            end
            default:
            begin
                if (b == SYNC_FIRST)
                begin
                    frame_xor  = SYNC_FIRST;
                    link_phase = PH_SYNC2;
                end
                else
                    link_phase = PH_HUNT;
            end
        endcase
    endtask

    task automatic add_byte(input logic [7:0] b, input logic err, input logic busy);
        byte_feed.push_back({b, err, busy});
    endtask

    task automatic queue_frame(input logic [PAYLOAD_LEN*8-1:0] body, input bit corrupt,
                               input bit busy, input bit noisy);
        logic [7:0] sum;
        int k;
        sum = SYNC_FIRST ^ SYNC_SECOND;
        add_byte(SYNC_FIRST, 1'b0, 1'($urandom_range(1)));
        add_byte(SYNC_SECOND, 1'b0, 1'($urandom_range(1)));
        for (k = 0; k < PAYLOAD_LEN; k++)
        begin
            if (noisy && $urandom_range(3) == 0)
                add_byte(8'($urandom_range(255)), 1'b1, 1'($urandom_range(1)));
            add_byte(body[k*8 +: 8], 1'b0, 1'($urandom_range(1)));
            sum = sum ^ body[k*8 +: 8];
        end
        if (corrupt)
            sum = sum ^ 8'($urandom_range(1, 255));
        add_byte(sum, 1'b0, busy);
    endtask

    function automatic bit steady();
        return cyc >= STEADY_FROM && cyc < STEADY_TO;
    endfunction

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin : drive_bytes
        rx_beat_t nxt;
        if (!rst_n)
        begin
            push        <= 1'b0;
            rx_byte     <= 8'h00;
            line_error  <= 1'b0;
            output_busy <= 1'b0;
        end
        else
        begin
            if (push && !full)
                parse_byte(rx_byte, line_error, output_busy);
            if (!push || !full)
            begin
                if (byte_feed.size() > 0 && (steady() || $urandom_range(99) >= 7))
                begin
                    nxt = byte_feed.pop_front();
                    push        <= 1'b1;
                    rx_byte     <= nxt.data;
                    line_error  <= nxt.err;
                    output_busy <= nxt.busy;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // payload monitor, with one long hold-off to back the block up
    always @(posedge clk or negedge rst_n)
    begin : watch_payload
        payload_beat_t want;
        int beats_seen;
        int hold_left;
        bit hold_done;
        if (!rst_n)
        begin
            pop        <= 1'b0;
            beats_seen = 0;
            hold_left  = 0;
            hold_done  = 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                beats_seen++;
                if (payload_due.size() == 0)
                begin
                    $error("unexpected payload beat: payload_byte=%h byte_index=%0d last_byte=%b",
                           payload_byte, byte_index, last_byte);
                    mismatches++;
                end
                else
                begin
                    want = payload_due.pop_front();
                    if (payload_byte !== want.data)
                    begin
                        $error("payload_byte: expected %h, got %h", want.data, payload_byte);
                        mismatches++;
                    end
                    if (byte_index !== want.idx)
                    begin
                        $error("byte_index: expected %0d, got %0d", want.idx, byte_index);
                        mismatches++;
                    end
                    if (last_byte !== want.last)
                    begin
                        $error("last_byte: expected %b, got %b", want.last, last_byte);
                        mismatches++;
                    end
                end
                if (!hold_done && beats_seen == HOLD_AFTER)
                begin
                    hold_done = 1'b1;
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= steady() || $urandom_range(99) >= 7;
        end
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (!rst_n || (push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : watchdog
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("sync_xor_frame_receiver_tb: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        logic [PAYLOAD_LEN*8-1:0] body;
        int sel;
        int k;
        int cut;

        // directed: stray bytes, a flagged sync, a repeated sync, a clean frame
        // with edge-value payload, then a good frame while the consumer is busy
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(SYNC_FIRST, 1'b1, 1'b0);
        add_byte(SYNC_FIRST, 1'b0, 1'b0);
        add_byte(SYNC_FIRST, 1'b0, 1'b0);
        add_byte(SYNC_SECOND, 1'b0, 1'b0);
        queue_frame({8'h55, 8'h7F, 8'h80, 8'h01, SYNC_SECOND, SYNC_FIRST, 8'hFF, 8'h00},
                    1'b0, 1'b0, 1'b0);
        for (k = 0; k < PAYLOAD_LEN; k++)
            body[k*8 +: 8] = 8'($urandom_range(255));
        queue_frame(body, 1'b0, 1'b1, 1'b0);

        // random: mostly whole frames, some broken headers, cut frames and noise
        while (byte_feed.size() < RAND_BYTES)
        begin
            sel = $urandom_range(99);
            for (k = 0; k < PAYLOAD_LEN; k++)
                body[k*8 +: 8] = 8'($urandom_range(255));
            if (sel < 75)
                queue_frame(body, $urandom_range(9) == 0, $urandom_range(9) == 0,
                            $urandom_range(3) == 0);
            else if (sel < 85)
            begin
                add_byte(SYNC_FIRST, 1'b0, 1'($urandom_range(1)));
                add_byte($urandom_range(1) ? SYNC_FIRST : 8'($urandom_range(255)), 1'b0,
                         1'($urandom_range(1)));
            end
            else if (sel < 93)
            begin
                cut = $urandom_range(PAYLOAD_LEN - 1);
                add_byte(SYNC_FIRST, 1'b0, 1'b0);
                add_byte(SYNC_SECOND, 1'b0, 1'b0);
                for (k = 0; k < cut; k++)
                    add_byte(body[k*8 +: 8], 1'b0, 1'($urandom_range(1)));
            end
            else
                add_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // check between edges so the driver and monitor have settled
        while (byte_feed.size() > 0 || push)
            @(negedge clk);
        while (payload_due.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && payload_due.size() == 0)
            $display("sync_xor_frame_receiver_tb: PASS");
        else
            $display("sync_xor_frame_receiver_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
